>>> hw/rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_INVERSE = 2'd1;
   localparam logic [1:0] STATUS_MOD_ZERO   = 2'd2;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // capture operands, magnitudes
      OP_RED_START, // start base mod m
      OP_RED_STEP,  // one bit of base mod m
      OP_RED_DONE,  // apply base sign
      OP_INV_INIT,  // set up extended Euclid
      OP_DIV_STEP,  // one bit of r_prev / r_cur
      OP_INV_MUL,   // start q*c_cur mod m
      OP_INV_UPD,   // rotate Euclid registers
      OP_MUL_ACC,   // start acc*sq mod m
      OP_MUL_SQ,    // start sq*sq mod m
      OP_MM_STEP,   // one bit of modular multiply
      OP_ACC_WB,    // write product to acc, start sq*sq mod m
      OP_SQ_WB,     // write product to sq, shift exponent
      OP_SET_ONE,   // sq = 1 (modulus of one)
      OP_INV_WB     // sq = inverse
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic mod_one;
      logic exp_neg;
      logic exp_zero;
      logic exp_lsb;
      logic cnt_last;
      logic r_cur_zero;
      logic inv_ok;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RED,
      ST_RED_DONE,
      ST_INV_INIT,
      ST_INV_TEST,
      ST_DIV,
      ST_INV_MUL,
      ST_INV_MM,
      ST_INV_UPD,
      ST_EXP,
      ST_ACC_MUL,
      ST_ACC_WB,
      ST_SQ_MUL,
      ST_SQ_WB,
      ST_OUT
   } ctrl_state_type;

endpackage

>>> hw/rtl/modexp_datapath.sv
// Datapath: operand registers, shared bit-serial divider and modular multiplier.
module modexp_datapath
   import modexp_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [WIDTH-1:0] in_base,
   input  logic [WIDTH-1:0] in_power,
   input  logic [WIDTH-1:0] in_modulus,
   output dp_status_type status,
   output logic [WIDTH-1:0] acc_value
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic             bneg_ff, bneg_in;
   logic             eneg_ff, eneg_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   // Divider / reduction
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   // Euclid
   logic [WIDTH-1:0] rp_ff, rp_in, rc_ff, rc_in, cp_ff, cp_in, cc_ff, cc_in;
   // Multiplier
   logic [WIDTH-1:0] ma_ff, ma_in, mb_ff, mb_in, mr_ff, mr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic [WIDTH:0]   rem_sh;
   logic [WIDTH-1:0] rem_nx;
   logic             rem_ge;
   logic [WIDTH:0]   dbl, dbl_add;
   logic [WIDTH-1:0] dbl_r, add_r;
   logic [WIDTH-1:0] base_mag, pow_mag, mod_mag;
   logic [WIDTH-1:0] rnext, cnext;

   always_comb begin
      base_mag = in_base[WIDTH-1] ? (~in_base + 1'b1) : in_base;
      pow_mag  = in_power[WIDTH-1] ? (~in_power + 1'b1) : in_power;
      mod_mag  = in_modulus[WIDTH-1] ? (~in_modulus + 1'b1) : in_modulus;
      // restoring division step
      rem_sh = {rem_ff, dvd_ff[WIDTH-1]};
      rem_ge = (rem_sh >= {1'b0, dvs_ff});
      rem_nx = rem_ge ? WIDTH'(rem_sh - {1'b0, dvs_ff}) : rem_sh[WIDTH-1:0];
      // double-and-add step
      dbl     = {mr_ff, 1'b0};
      dbl_r   = (dbl >= {1'b0, m_ff}) ? WIDTH'(dbl - {1'b0, m_ff}) : dbl[WIDTH-1:0];
      dbl_add = {1'b0, dbl_r} + {1'b0, ma_ff};
      add_r   = (dbl_add >= {1'b0, m_ff}) ? WIDTH'(dbl_add - {1'b0, m_ff})
                                          : dbl_add[WIDTH-1:0];
      rnext = rem_ff;
      cnext = (cp_ff >= mr_ff) ? cp_ff - mr_ff : cp_ff + (m_ff - mr_ff);
   end

   always_comb begin
      m_in = m_ff; e_in = e_ff; bneg_in = bneg_ff; eneg_in = eneg_ff;
      sq_in = sq_ff; acc_in = acc_ff; dvd_in = dvd_ff; rem_in = rem_ff;
      dvs_in = dvs_ff; rp_in = rp_ff; rc_in = rc_ff; cp_in = cp_ff; cc_in = cc_ff;
      ma_in = ma_ff; mb_in = mb_ff; mr_in = mr_ff; cnt_in = cnt_ff;
      case (cmd.op)
         OP_LOAD: begin
            m_in = mod_mag; e_in = pow_mag;
            bneg_in = in_base[WIDTH-1]; eneg_in = in_power[WIDTH-1];
            dvd_in = base_mag; acc_in = WIDTH'(1);
         end
         OP_RED_START: begin
            rem_in = '0; dvs_in = m_ff; cnt_in = '0;
         end
         OP_RED_STEP, OP_DIV_STEP: begin
            rem_in = rem_nx;
            dvd_in = {dvd_ff[WIDTH-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_RED_DONE: begin
            sq_in = (bneg_ff && rem_ff != '0) ? m_ff - rem_ff : rem_ff;
         end
         OP_INV_INIT: begin
            rp_in = m_ff; rc_in = sq_ff; cp_in = '0; cc_in = WIDTH'(1);
            dvd_in = m_ff; dvs_in = sq_ff; rem_in = '0; cnt_in = '0;
         end
         OP_INV_MUL: begin
            // quotient in dvd; reduce c_cur below m
            ma_in = (cc_ff >= m_ff) ? cc_ff - m_ff : cc_ff;
            mb_in = dvd_ff; mr_in = '0; cnt_in = '0;
         end
         OP_INV_UPD: begin
            rp_in = rc_ff; rc_in = rnext;
            cp_in = cc_ff; cc_in = cnext;
            dvd_in = rc_ff; dvs_in = rnext; rem_in = '0; cnt_in = '0;
         end
         OP_MUL_ACC: begin
            ma_in = acc_ff; mb_in = sq_ff; mr_in = '0; cnt_in = '0;
         end
         OP_MUL_SQ: begin
            ma_in = sq_ff; mb_in = sq_ff; mr_in = '0; cnt_in = '0;
         end
         OP_MM_STEP: begin
            mr_in  = mb_ff[WIDTH-1] ? add_r : dbl_r;
            mb_in  = {mb_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_ACC_WB: begin
            acc_in = mr_ff;
            ma_in = sq_ff; mb_in = sq_ff; mr_in = '0; cnt_in = '0;
         end
         OP_SQ_WB: begin
            sq_in = mr_ff; e_in = {1'b0, e_ff[WIDTH-1:1]};
         end
         OP_SET_ONE: sq_in = WIDTH'(1);
         OP_INV_WB: sq_in = cp_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; e_ff <= e_in; bneg_ff <= bneg_in; eneg_ff <= eneg_in;
      sq_ff <= sq_in; acc_ff <= acc_in; dvd_ff <= dvd_in; rem_ff <= rem_in;
      dvs_ff <= dvs_in; rp_ff <= rp_in; rc_ff <= rc_in; cp_ff <= cp_in;
      cc_ff <= cc_in; ma_ff <= ma_in; mb_ff <= mb_in; mr_ff <= mr_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      status.mod_zero   = (m_ff == '0);
      status.mod_one    = (m_ff == WIDTH'(1));
      status.exp_neg    = eneg_ff;
      status.exp_zero   = (e_ff == '0);
      status.exp_lsb    = e_ff[0];
      status.cnt_last   = (cnt_ff == CW'(WIDTH - 1));
      status.r_cur_zero = (rc_ff == '0);
      status.inv_ok     = (rp_ff == WIDTH'(1)) && (cp_ff != '0);
   end

   assign acc_value = acc_ff;

endmodule

>>> hw/rtl/modexp_ctrl.sv
// Controller state machine sequencing reduction, inversion and exponentiation.
module modexp_ctrl
   import modexp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          out_free,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          done,
   output logic [1:0]    done_status
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stat_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      cmd.op   = OP_NONE;
      done     = 1'b0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op = OP_LOAD;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.mod_zero) begin
               stat_in = STATUS_MOD_ZERO;
               state_in = ST_OUT;
            end else begin
               stat_in = STATUS_OK;
               cmd.op = OP_RED_START;
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            cmd.op = OP_RED_STEP;
            if (status.cnt_last) state_in = ST_RED_DONE;
         end
         ST_RED_DONE: begin
            cmd.op = OP_RED_DONE;
            state_in = status.exp_neg ? ST_INV_INIT : ST_EXP;
         end
         ST_INV_INIT: begin
            if (status.mod_one) begin
               cmd.op = OP_SET_ONE;
               state_in = ST_EXP;
            end else begin
               cmd.op = OP_INV_INIT;
               state_in = ST_INV_TEST;
            end
         end
         ST_INV_TEST: begin
            // loop test on r_cur, then divide
            if (status.r_cur_zero) begin
               if (status.inv_ok) begin
                  cmd.op = OP_INV_WB;
                  state_in = ST_EXP;
               end else begin
                  stat_in = STATUS_NO_INVERSE;
                  state_in = ST_OUT;
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.cnt_last) state_in = ST_INV_MUL;
         end
         ST_INV_MUL: begin
            cmd.op = OP_INV_MUL;
            state_in = ST_INV_MM;
         end
         ST_INV_MM: begin
            cmd.op = OP_MM_STEP;
            if (status.cnt_last) state_in = ST_INV_UPD;
         end
         ST_INV_UPD: begin
            cmd.op = OP_INV_UPD;
            state_in = ST_INV_TEST;
         end
         ST_EXP: begin
            if (status.exp_zero) begin
               state_in = ST_OUT;
            end else if (status.exp_lsb) begin
               cmd.op = OP_MUL_ACC;
               state_in = ST_ACC_MUL;
            end else begin
               cmd.op = OP_MUL_SQ;
               state_in = ST_SQ_MUL;
            end
         end
         ST_ACC_MUL: begin
            cmd.op = OP_MM_STEP;
            if (status.cnt_last) state_in = ST_ACC_WB;
         end
         ST_ACC_WB: begin
            cmd.op = OP_ACC_WB;
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            cmd.op = OP_MM_STEP;
            if (status.cnt_last) state_in = ST_SQ_WB;
         end
         ST_SQ_WB: begin
            cmd.op = OP_SQ_WB;
            state_in = ST_EXP;
         end
         ST_OUT: begin
            if (out_free) begin
               done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign done_status = stat_ff;

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block.
//
// One item at a time: a zero modulus goes straight to the output; otherwise the
// base is reduced by the bit-serial divider, a negative exponent adds an extended
// Euclid inversion of one division and one modular multiplication per quotient
// step, and each exponent bit costs one or two bit-serial modular multiplications
// through the single shared double-and-add unit.
// The result waits in an output register, so the next item may be accepted
// as soon as the previous one has left the datapath.
module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // base_value[63:0], power[127:64], modulus_value[191:128]
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_value[62:0]
   output logic [63:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   dp_cmd_type       cmd;
   dp_status_type    dst;
   logic [WIDTH-1:0] acc_value;
   logic             busy, done, start, out_free;
   logic [1:0]       done_status;
   logic             vld_ff, vld_in;
   logic [62:0]      res_ff, res_in;
   logic [1:0]       st_ff, st_in;
   logic [63:0]      acc_ext;

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !vld_ff || rsp_tready;

   modexp_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_base    (req_tdata[WIDTH-1:0]),
      .in_power   (req_tdata[64+WIDTH-1:64]),
      .in_modulus (req_tdata[128+WIDTH-1:128]),
      .status     (dst),
      .acc_value  (acc_value)
   );

   modexp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .out_free    (out_free),
      .status      (dst),
      .cmd         (cmd),
      .busy        (busy),
      .done        (done),
      .done_status (done_status)
   );

   assign acc_ext = 64'(acc_value);

   always_comb begin
      vld_in = vld_ff && !rsp_tready;
      res_in = res_ff;
      st_in  = st_ff;
      if (done) begin
         vld_in = 1'b1;
         st_in  = done_status;
         res_in = (done_status == STATUS_OK) ? acc_ext[62:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      st_ff  <= st_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {1'b0, res_ff};
   assign rsp_tuser  = st_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("item accepted but controller not busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> rsp_tdata == '0)
      else $error("error item carries nonzero result");
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free) else $error("result overwrote a waiting item");
`endif

endmodule

>>> verif/tb_modular_exponentiation.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module tb_modular_exponentiation;
   import modexp_pkg::*;

   localparam int IDLE_LIMIT  = 100000; // cycles with no item moving on either side
   localparam int DRAIN_WAIT  = 200;
   localparam int RANDOM_RUNS = 75;

   typedef struct packed {
      logic [62:0] value;
      logic [1:0]  status;
   } modpow_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // base_value[63:0], power[127:64], modulus_value[191:128]
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // result_value[62:0]
   logic [63:0]  rsp_tdata;
   // status[1:0]
   logic [1:0]   rsp_tuser;

   modpow_type expected_q[$];
   int      error_count = 0;
   bit      gaps_on = 1'b1;
   int      hold_off = 0;

   modular_exponentiation #(.WIDTH(64)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] mul_mod64(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod % {64'd0, m};
      return prod[63:0];
   endfunction

   // Extended Euclid; returns 0 when gcd(a, m) is not one.
   function automatic bit find_inverse(logic [63:0] a, logic [63:0] m,
                                       output logic [63:0] inv);
      logic [63:0] r_old, r_now, r_new, c_old, c_now, c_new, q, t;
      r_old = m; r_now = a; c_old = 0; c_now = 1; inv = 0;
      while (r_now != 0) begin
         q = r_old / r_now;
         r_new = r_old - q * r_now;
         t = mul_mod64(q, c_now, m);
         c_new = (c_old >= t) ? c_old - t : c_old + (m - t);
         r_old = r_now; r_now = r_new;
         c_old = c_now; c_now = c_new;
      end
      inv = c_old;
      return r_old == 1;
   endfunction

   function automatic modpow_type compute_modpow(logic [63:0] b, logic [63:0] p,
                                                 logic [63:0] m);
      logic [63:0] bmag, e, mmag, sq, acc, inv;
      modpow_type  r;
      bmag = b[63] ? -b : b;
      e    = p[63] ? -p : p;
      mmag = m[63] ? -m : m;
      if (mmag == 0) begin
         r.value = 0; r.status = STATUS_MOD_ZERO;
         return r;
      end
      sq = bmag % mmag;
      if (b[63] && sq != 0) sq = mmag - sq;
      if (p[63]) begin
         if (mmag == 1) begin
            sq = 1;
         end else begin
            if (!find_inverse(sq, mmag, inv) || inv == 0) begin
               r.value = 0; r.status = STATUS_NO_INVERSE;
               return r;
            end
            sq = inv;
         end
      end
      acc = 1;
      while (e != 0) begin
         if (e[0]) acc = mul_mod64(acc, sq, mmag);
         e = e >> 1;
         sq = mul_mod64(sq, sq, mmag);
      end
      r.value = acc[62:0]; r.status = STATUS_OK;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(logic [63:0] b, logic [63:0] p, logic [63:0] m);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tdata  = {m, p, b};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(compute_modpow(b, p, m));
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Keep the exponent and modulus off the most negative code.
   function automatic logic [63:0] no_min(logic [63:0] v);
      return (v == 64'h8000_0000_0000_0000) ? v + 1 : v;
   endfunction

   function automatic logic [63:0] rand_bits(int unsigned nbits);
      logic [63:0] v;
      v = rand64();
      return (nbits >= 64) ? v : v & ((64'd1 << nbits) - 1);
   endfunction

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready = 1'b0;
            hold_off--;
         end else if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            stall = $urandom_range(1, 17) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      modpow_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item result=%h status=%0d",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== {1'b0, want.value}) begin
               $display("%0t: result_value expected %h actual %h",
                        $time, {1'b0, want.value}, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // watchdog: count cycles in which nothing moves
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic test_special_cases();
      send_item(64'd5, 64'd3, 64'd0);                      // zero modulus
      send_item(-64'sd7, -64'sd2, 64'd0);
      send_item(64'd9, 64'd0, 64'd1);                      // exponent zero, unreduced
      send_item(64'd9, 64'd0, -64'sd13);
      send_item(64'd4, -64'sd5, 64'd1);                    // modulus one, negative exponent
      send_item(64'd4, -64'sd5, -64'sd1);
      send_item(64'd6, -64'sd1, 64'd9);                    // no inverse
      send_item(64'd0, -64'sd3, 64'd7);
      send_item(64'd3, -64'sd1, 64'd7);                    // plain inverse
      send_item(-64'sd3, -64'sd2, -64'sd11);
      send_item(64'd2, 64'd10, 64'd1000);
      send_item(-64'sd2, 64'd3, 64'd5);
   endtask

   task automatic test_extremes();
      send_item(64'h8000_0000_0000_0000, 64'd1, 64'h7fff_ffff_ffff_ffff);
      send_item(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                64'h7fff_ffff_ffff_ffff);
      send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                64'h8000_0000_0000_0001);
      send_item(64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                64'h8000_0000_0000_0001);
      send_item(64'h7fff_ffff_ffff_fffe, -64'sd1, 64'h7fff_ffff_ffff_ffe7);
      send_item(64'h0123_4567_89ab_cdef, 64'h5555_aaaa_5555_aaaa,
                64'h7edc_ba98_7654_3211);
      send_item(rand64(), 64'hffff_ffff_ffff_fffe, 64'd2);
   endtask

   task automatic test_backpressure();
      hold_off = 3000;
      repeat (6) send_item(rand64(), rand_bits(4), no_min(rand64()));
   endtask

   task automatic test_random();
      logic [63:0] b, p, m;
      for (int i = 0; i < RANDOM_RUNS; i++) begin
         if (i == RANDOM_RUNS - 20) gaps_on = 1'b0;
         b = rand64();
         case ($urandom_range(0, 9))
            0:       p = no_min(rand64());
            1, 2, 3: p = rand_bits($urandom_range(1, 12));
            default: p = rand_bits($urandom_range(1, 20));
         endcase
         if ($urandom_range(0, 2) == 0) p = no_min(-p);
         case ($urandom_range(0, 9))
            0:       m = rand_bits($urandom_range(0, 4));
            1, 2:    m = rand_bits($urandom_range(5, 32));
            default: m = rand_bits(64);
         endcase
         if ($urandom_range(0, 1) == 0) m = -m;
         send_item(b, p, no_min(m));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_special_cases();
      test_extremes();
      test_backpressure();
      test_random();
      req_tvalid = 1'b0;
      wait (expected_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_datapath.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
